// ===== hdl/ppurp_pkg.sv =====
// Shared types and constants for the picture-unit register port.
// Used by ppurp_ram, ppurp_core and ppu_register_port_top; no dependencies.
package ppurp_pkg;

	// memory geometry
	localparam int NT_AW     = 11;
	localparam int SPR_AW    = 8;
	localparam int PAL_AW    = 5;
	localparam int NT_DEPTH  = 1 << NT_AW;
	localparam int SPR_DEPTH = 1 << SPR_AW;
	localparam int PAL_DEPTH = 1 << PAL_AW;

	localparam logic [7:0] NT_RESET_BYTE = 8'hFF;
	localparam logic [7:0] GRAY_MASK     = 8'h30;
	localparam logic [5:0] PAL_PAGE      = 6'h3F;

	// command codes
	typedef enum logic [2:0] {
		CMD_WRITE    = 3'd0,
		CMD_READ     = 3'd1,
		CMD_VBLANK   = 3'd2,
		CMD_OVERFLOW = 3'd3,
		CMD_SPR0_HIT = 3'd4,
		CMD_CLEAR    = 3'd5
	} cmd_t;

	// register window
	localparam logic [2:0] REG_CTRL     = 3'd0;
	localparam logic [2:0] REG_MASK     = 3'd1;
	localparam logic [2:0] REG_STATUS   = 3'd2;
	localparam logic [2:0] REG_OAM_ADDR = 3'd3;
	localparam logic [2:0] REG_OAM_DATA = 3'd4;
	localparam logic [2:0] REG_SCROLL   = 3'd5;
	localparam logic [2:0] REG_ADDR     = 3'd6;
	localparam logic [2:0] REG_DATA     = 3'd7;

	typedef enum logic {
		ST_IDLE,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic              rd_en;
		logic              nt_we;
		logic              pal_we;
		logic              spr_we;
		logic [NT_AW-1:0]  nt_idx;
		logic [PAL_AW-1:0] pal_idx;
		logic [SPR_AW-1:0] spr_idx;
		logic [7:0]        wdata;
	} mem_req_t;

	typedef struct packed {
		logic [7:0] nt_rdata;
		logic [7:0] pal_rdata;
		logic [7:0] spr_rdata;
	} mem_rsp_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [14:0] vram_address;
		logic [2:0]  fine_x;
		logic [7:0]  control;
		logic [7:0]  mask;
		logic        strobe;
	} result_t;

endpackage

// ===== hdl/ppu_register_port_top.sv =====
// Top level of the picture-unit register port: configuration register,
// output register and instances of ppurp_core and ppurp_ram (ppurp_pkg).
//
// Usage
//   Input channel (in_valid/in_stall): one transaction carries command,
//   reg_index and write_data. Output channel (out_valid/out_stall): one
//   result per input transaction, with the bus latch, the current VRAM
//   address, fine X, control and mask bytes and the pattern write strobe.
//   cfg_we/cfg_wdata set the nametable mirroring (0 vertical, 1 horizontal);
//   write it only while no transaction is in flight.
// Sequencing
//   A transaction is taken in ST_IDLE (memory read issued) and completed
//   in ST_RESP, once the registered read data is back and the output
//   register is free; no new transaction is taken until then.
//   The result is captured in the output register at completion.
// Reset
//   After arst_n is released the nametable, sprite and palette memories are
//   swept, one entry per cycle, until all 2048 nametable entries are cleared;
//   in_stall is held high during the sweep. Configuration writes are taken throughout.
// Stalling
//   A held result stays on the outputs. One further transaction may be
//   accepted meanwhile; it completes once the output register frees up.
module ppu_register_port_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [2:0]  reg_index,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic [14:0] vram_address,
	output logic [2:0]  fine_x_out,
	output logic [7:0]  control_out,
	output logic [7:0]  mask_out,
	output logic        pattern_write_strobe
);
	import ppurp_pkg::*;

	logic     mirroring_q;
	logic     out_valid_q;
	logic     out_free;
	logic     commit;
	logic     clr_busy;
	mem_req_t mem_req;
	mem_rsp_t mem_rsp;
	result_t  result;
	result_t  res_q;

	// mirroring register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mirroring_q <= 1'b0;
		else if (cfg_we)
			mirroring_q <= cfg_wdata;
	end

	assign out_free = !out_valid_q || !out_stall;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (commit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (commit)
			res_q <= result;
	end

	assign out_valid            = out_valid_q;
	assign read_data            = res_q.read_data;
	assign vram_address         = res_q.vram_address;
	assign fine_x_out           = res_q.fine_x;
	assign control_out          = res_q.control;
	assign mask_out             = res_q.mask;
	assign pattern_write_strobe = res_q.strobe;

	ppurp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.reg_index  (reg_index),
		.write_data (write_data),
		.mirroring  (mirroring_q),
		.clr_busy   (clr_busy),
		.out_free   (out_free),
		.mem_req    (mem_req),
		.mem_rsp    (mem_rsp),
		.commit     (commit),
		.result     (result)
	);

	ppurp_ram u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mem_req),
		.rsp      (mem_rsp),
		.clr_busy (clr_busy)
	);

endmodule

// ===== hdl/ppurp_ram.sv =====
// Nametable, palette and sprite memories with registered reads and the
// post-reset clearing sweep. Depends on ppurp_pkg.
module ppurp_ram (
	input  logic                clk,
	input  logic                arst_n,
	input  ppurp_pkg::mem_req_t req,
	output ppurp_pkg::mem_rsp_t rsp,
	output logic                clr_busy
);
	import ppurp_pkg::*;

	logic [7:0] nt_mem  [NT_DEPTH];
	logic [7:0] spr_mem [SPR_DEPTH];
	logic [7:0] pal_mem [PAL_DEPTH];

	logic [NT_AW-1:0] clr_cnt_q;
	logic             clr_busy_q;

	logic [7:0] nt_rdata_q;
	logic [7:0] spr_rdata_q;
	logic [7:0] pal_rdata_q;

	// clearing sweep, one entry of each memory per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (&clr_cnt_q)
				clr_busy_q <= 1'b0;
		end
	end

	assign clr_busy = clr_busy_q;

	// nametable RAM
	always_ff @(posedge clk) begin
		if (clr_busy_q)
			nt_mem[clr_cnt_q] <= NT_RESET_BYTE;
		else if (req.nt_we)
			nt_mem[req.nt_idx] <= req.wdata;
		if (req.rd_en)
			nt_rdata_q <= nt_mem[req.nt_idx];
	end

	// sprite RAM
	always_ff @(posedge clk) begin
		if (clr_busy_q)
			spr_mem[clr_cnt_q[SPR_AW-1:0]] <= '0;
		else if (req.spr_we)
			spr_mem[req.spr_idx] <= req.wdata;
		if (req.rd_en)
			spr_rdata_q <= spr_mem[req.spr_idx];
	end

	// palette RAM
	always_ff @(posedge clk) begin
		if (clr_busy_q)
			pal_mem[clr_cnt_q[PAL_AW-1:0]] <= '0;
		else if (req.pal_we)
			pal_mem[req.pal_idx] <= req.wdata;
		if (req.rd_en)
			pal_rdata_q <= pal_mem[req.pal_idx];
	end

	assign rsp = '{
		nt_rdata:  nt_rdata_q,
		pal_rdata: pal_rdata_q,
		spr_rdata: spr_rdata_q
	};

endmodule

// ===== hdl/ppurp_core.sv =====
// Register file, scroll address logic and two-phase sequencer of the
// register port. Depends on ppurp_pkg; drives the memories in ppurp_ram.
module ppurp_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          command,
	input  logic [2:0]          reg_index,
	input  logic [7:0]          write_data,
	input  logic                mirroring,
	input  logic                clr_busy,
	input  logic                out_free,
	output ppurp_pkg::mem_req_t mem_req,
	input  ppurp_pkg::mem_rsp_t mem_rsp,
	output logic                commit,
	output ppurp_pkg::result_t  result
);
	import ppurp_pkg::*;

	state_t state_q, state_d;
	logic   accept;

	// latched transaction
	logic [2:0] cmd_q, reg_q;
	logic [7:0] data_q;

	// architectural state
	logic [7:0]  ctrl_q, mask_q, ptr_q, rbuf_q, latch_q;
	logic [2:0]  flags_q, fx_q;
	logic [14:0] tmp_q, cur_q;
	logic        tog_q;

	logic [7:0]  ctrl_d, mask_d, ptr_d, rbuf_d, latch_d;
	logic [2:0]  flags_d, fx_d;
	logic [14:0] tmp_d, cur_d;
	logic        tog_d, strobe_d;

	logic [13:0] addr;
	logic        in_pattern, in_palette, in_nt;
	logic [13:0] addr_next;
	logic [7:0]  vram_val;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		accept   = 1'b0;
		commit   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = clr_busy;
				accept   = in_valid && !clr_busy;
				if (accept)
					state_d = ST_RESP;
			end
			ST_RESP: begin
				commit = out_free;
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= command;
			reg_q  <= reg_index;
			data_q <= write_data;
		end
	end

	// address decode
	assign addr       = cur_q[13:0];
	assign in_pattern = !addr[13];
	assign in_palette = addr[13:8] == PAL_PAGE;
	assign in_nt      = !in_pattern && !in_palette;
	assign addr_next  = addr + (ctrl_q[2] ? 14'd32 : 14'd1);

	// memory requests: read on accept, write on commit
	always_comb begin
		mem_req.rd_en   = accept;
		mem_req.nt_idx  = {mirroring ? addr[11] : addr[10], addr[9:0]};
		mem_req.pal_idx = (addr[4] && addr[1:0] == 2'b00) ? {1'b0, addr[3:0]} : addr[4:0];
		mem_req.spr_idx = ptr_q;
		mem_req.wdata   = data_q;
		mem_req.nt_we   = commit && cmd_q == CMD_WRITE && reg_q == REG_DATA && in_nt;
		mem_req.pal_we  = commit && cmd_q == CMD_WRITE && reg_q == REG_DATA && in_palette;
		mem_req.spr_we  = commit && cmd_q == CMD_WRITE && reg_q == REG_OAM_DATA;
	end

	// byte seen by a data read
	always_comb begin
		if (in_pattern)
			vram_val = '0;
		else if (in_nt)
			vram_val = mem_rsp.nt_rdata;
		else
			vram_val = mem_rsp.pal_rdata & (mask_q[0] ? GRAY_MASK : 8'hFF);
	end

	// next state of the register file
	always_comb begin
		ctrl_d   = ctrl_q;
		mask_d   = mask_q;
		ptr_d    = ptr_q;
		rbuf_d   = rbuf_q;
		latch_d  = latch_q;
		flags_d  = flags_q;
		fx_d     = fx_q;
		tmp_d    = tmp_q;
		cur_d    = cur_q;
		tog_d    = tog_q;
		strobe_d = 1'b0;
		case (cmd_q)
			CMD_WRITE: begin
				latch_d = data_q;
				case (reg_q)
					REG_CTRL: begin
						ctrl_d       = data_q;
						tmp_d[11:10] = data_q[1:0];
					end
					REG_MASK:     mask_d = data_q;
					REG_OAM_ADDR: ptr_d  = data_q;
					REG_OAM_DATA: ptr_d  = ptr_q + 8'd1;
					REG_SCROLL: begin
						if (!tog_q) begin
							fx_d       = data_q[2:0];
							tmp_d[4:0] = data_q[7:3];
						end else begin
							tmp_d[14:12] = data_q[2:0];
							tmp_d[9:5]   = data_q[7:3];
						end
						tog_d = !tog_q;
					end
					REG_ADDR: begin
						if (!tog_q) begin
							tmp_d = {1'b0, data_q[5:0], tmp_q[7:0]};
						end else begin
							tmp_d = {tmp_q[14:8], data_q};
							cur_d = {tmp_q[14:8], data_q};
						end
						tog_d = !tog_q;
					end
					REG_DATA: begin
						strobe_d = in_pattern;
						cur_d    = {cur_q[14], addr_next};
					end
					default: ;
				endcase
			end
			CMD_READ: begin
				case (reg_q)
					REG_STATUS: begin
						latch_d    = {flags_q, latch_q[4:0]};
						flags_d[2] = 1'b0;
						tog_d      = 1'b0;
					end
					REG_OAM_DATA: latch_d = mem_rsp.spr_rdata;
					REG_DATA: begin
						// palette reads skip the buffer
						rbuf_d  = vram_val;
						latch_d = in_palette ? vram_val : rbuf_q;
						cur_d   = {cur_q[14], addr_next};
					end
					default: ;
				endcase
			end
			CMD_VBLANK:   flags_d[2] = 1'b1;
			CMD_OVERFLOW: flags_d[0] = 1'b1;
			CMD_SPR0_HIT: flags_d[1] = 1'b1;
			CMD_CLEAR:    flags_d    = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q  <= '0;
			mask_q  <= '0;
			ptr_q   <= '0;
			rbuf_q  <= '0;
			latch_q <= '0;
			flags_q <= '0;
			fx_q    <= '0;
			tmp_q   <= '0;
			cur_q   <= '0;
			tog_q   <= 1'b0;
		end else if (commit) begin
			ctrl_q  <= ctrl_d;
			mask_q  <= mask_d;
			ptr_q   <= ptr_d;
			rbuf_q  <= rbuf_d;
			latch_q <= latch_d;
			flags_q <= flags_d;
			fx_q    <= fx_d;
			tmp_q   <= tmp_d;
			cur_q   <= cur_d;
			tog_q   <= tog_d;
		end
	end

	assign result = '{
		read_data:    latch_d,
		vram_address: cur_d,
		fine_x:       fx_d,
		control:      ctrl_d,
		mask:         mask_d,
		strobe:       strobe_d
	};

	// checks
	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !(mem_req.nt_we || mem_req.pal_we || mem_req.spr_we))
		else $error("memory write during clearing sweep");

	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP && !out_free) |=> (state_q == ST_RESP && $stable(cmd_q)
			&& $stable(reg_q) && $stable(data_q)))
		else $error("pending transaction lost while output blocked");

	a_strobe_source: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && strobe_d) |-> (cmd_q == CMD_WRITE && reg_q == REG_DATA))
		else $error("pattern strobe without a data write");

	a_incr_keeps_bit14: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && reg_q == REG_DATA && (cmd_q == CMD_WRITE || cmd_q == CMD_READ))
			|=> cur_q[14] == $past(cur_q[14]))
		else $error("address increment disturbed bit 14");

	a_accept_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (state_q == ST_IDLE && !clr_busy))
		else $error("transaction accepted while busy");

endmodule
